// ===== rtl/fba_pkg.sv =====
// fba_pkg: shared constants, types and codes for the file block allocator.
// No dependencies; used by every module in rtl.
package fba_pkg;

  localparam int DataBlocks     = 4096;
  localparam int FirstDataBlock = 130;
  localparam int BlockBytes     = 8192;
  localparam int FileSlots      = 128;
  localparam int BlocksPerFile  = 32;

  localparam int BlkW   = $clog2(DataBlocks);
  localparam int CntW   = $clog2(DataBlocks + 1);
  localparam int SlotW  = $clog2(FileSlots);
  localparam int OrdW   = $clog2(BlocksPerFile);
  localparam int NeedW  = $clog2(BlocksPerFile + 1);
  localparam int ShiftW = $clog2(BlockBytes);
  localparam int WordW  = 64;
  localparam int WordsN = DataBlocks / WordW;
  localparam int WordIW = $clog2(WordsN);
  localparam int BitIW  = $clog2(WordW);

  localparam int SizeW   = 20;
  localparam int StatusW = 3;
  localparam int FreeW   = 26;
  localparam int BnumW   = 13;
  localparam int InodeSizeW = 19;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_NODIR   = 3'd2,
    ST_NOINODE = 3'd3,
    ST_TOOBIG  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_EMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic check;
    logic scan_step;
    logic emit_ok;
    logic emit_fail;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic fail;
    logic scan_hit;
    logic scan_end;
    logic need_done;
  } stat_t;

endpackage

// ===== rtl/fba_datapath.sv =====
// fba_datapath: bitmaps, slot maps, inode stores and result registers.
// Depends on fba_pkg; driven by fba_ctrl through fba_pkg::cmd_t.
module fba_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  fba_pkg::cmd_t                     cmd,
  output fba_pkg::stat_t                    stat,
  input  logic [fba_pkg::SizeW-1:0]         size_in,
  output logic                              strobe,
  output logic [fba_pkg::StatusW-1:0]       status,
  output logic [fba_pkg::SlotW-1:0]         dir_slot,
  output logic [fba_pkg::SlotW-1:0]         inode_slot,
  output logic                              block_valid,
  output logic [fba_pkg::BnumW-1:0]         block_number,
  output logic [fba_pkg::OrdW-1:0]          block_ordinal,
  output logic [fba_pkg::FreeW-1:0]         free_bytes,
  output logic                              last
);

  // Block bitmap memory: one 64-bit word per row, registered read.
  logic [fba_pkg::WordW-1:0] bmap [fba_pkg::WordsN];
  logic [fba_pkg::WordIW:0]  rd_addr;
  logic [fba_pkg::WordW-1:0] rd_word;
  logic [fba_pkg::WordIW-1:0] rd_word_addr;
  logic                      rd_live;

  logic [fba_pkg::CntW-1:0]  free_cnt;
  logic [fba_pkg::FileSlots-1:0] dir_map;
  logic [fba_pkg::FileSlots-1:0] inode_map;
  logic [fba_pkg::SlotW-1:0] dir_inode_link [fba_pkg::FileSlots];
  logic [fba_pkg::InodeSizeW-1:0] inode_size [fba_pkg::FileSlots];
  logic [fba_pkg::NeedW-1:0] inode_cnt [fba_pkg::FileSlots];
  logic [fba_pkg::BlkW-1:0]  inode_list [fba_pkg::FileSlots * fba_pkg::BlocksPerFile];

  logic [fba_pkg::SizeW-1:0] size;
  logic [fba_pkg::NeedW-1:0] need;
  logic [fba_pkg::NeedW-1:0] got;
  logic [fba_pkg::SlotW-1:0] dir_sel;
  logic [fba_pkg::SlotW-1:0] ino_sel;
  logic [fba_pkg::StatusW-1:0] fail_code;

  // Result sweep state for successful requests.
  logic [fba_pkg::NeedW-1:0] emit_ord;
  logic                      emit_on;
  logic [fba_pkg::BlkW-1:0]  emit_blk;
  logic [fba_pkg::NeedW-1:0] emit_ord_d;
  logic                      emit_on_d;

  // Lowest free slots, lowest zero bit in the read word.
  logic                      dir_found, ino_found, bit_found;
  logic [fba_pkg::SlotW-1:0] dir_low, ino_low;
  logic [fba_pkg::BitIW-1:0] bit_low;

  always_comb begin
    dir_found = 1'b0;
    dir_low   = '0;
    for (int i = fba_pkg::FileSlots - 1; i >= 0; i--) begin
      if (!dir_map[i]) begin
        dir_found = 1'b1;
        dir_low   = fba_pkg::SlotW'(i);
      end
    end
    ino_found = 1'b0;
    ino_low   = '0;
    for (int i = fba_pkg::FileSlots - 1; i >= 0; i--) begin
      if (!inode_map[i]) begin
        ino_found = 1'b1;
        ino_low   = fba_pkg::SlotW'(i);
      end
    end
    bit_found = 1'b0;
    bit_low   = '0;
    for (int i = fba_pkg::WordW - 1; i >= 0; i--) begin
      if (!rd_word[i]) begin
        bit_found = 1'b1;
        bit_low   = fba_pkg::BitIW'(i);
      end
    end
  end

  logic [fba_pkg::SizeW:0] size_round;
  logic [fba_pkg::SizeW:0] avail_cap;
  assign size_round = {1'b0, size} + (fba_pkg::SizeW+1)'(fba_pkg::BlockBytes - 1);
  assign avail_cap  = (free_cnt >= fba_pkg::CntW'((1 << (fba_pkg::SizeW - fba_pkg::ShiftW + 1)) - 1))
                    ? '1 : (fba_pkg::SizeW+1)'({free_cnt, {fba_pkg::ShiftW{1'b0}}});

  logic [fba_pkg::BlkW-1:0] hit_blk;
  assign hit_blk = {rd_word_addr, bit_low};

  assign stat.clear_done = (rd_addr == (fba_pkg::WordIW+1)'(fba_pkg::WordsN - 1));
  assign stat.fail       = (fail_code != fba_pkg::ST_OK);
  assign stat.scan_hit   = rd_live && bit_found;
  // The last row is still in the read register when the address runs off the end.
  assign stat.scan_end   = (rd_addr == (fba_pkg::WordIW+1)'(fba_pkg::WordsN)) &&
                           rd_live && !bit_found;
  assign stat.need_done  = (got == need);

  always_ff @(posedge clk) begin
    if (cmd.clear_step) bmap[rd_addr[fba_pkg::WordIW-1:0]] <= '0;
    else if (cmd.scan_step && rd_live && bit_found && got != need)
      bmap[rd_word_addr] <= rd_word | (fba_pkg::WordW'(1) << bit_low);
    rd_word      <= bmap[rd_addr[fba_pkg::WordIW-1:0]];
    rd_word_addr <= rd_addr[fba_pkg::WordIW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr   <= '0;
      rd_live   <= 1'b0;
      free_cnt  <= fba_pkg::CntW'(fba_pkg::DataBlocks);
      dir_map   <= '0;
      inode_map <= '0;
      strobe    <= 1'b0;
      got       <= '0;
      fail_code <= fba_pkg::ST_OK;
    end else begin
      strobe <= 1'b0;
      if (cmd.clear_step) rd_addr <= rd_addr + 1'b1;
      if (cmd.load) begin
        size    <= size_in;
        got     <= '0;
        rd_addr <= '0;
        rd_live <= 1'b0;
      end
      if (cmd.check) begin
        need    <= fba_pkg::NeedW'(size_round >> fba_pkg::ShiftW);
        dir_sel <= dir_low;
        ino_sel <= ino_low;
        if ({1'b0, size} > (fba_pkg::SizeW+1)'(fba_pkg::BlocksPerFile * fba_pkg::BlockBytes))
          fail_code <= fba_pkg::ST_TOOBIG;
        else if ({1'b0, size} > avail_cap) fail_code <= fba_pkg::ST_NOSPACE;
        else if (!dir_found)               fail_code <= fba_pkg::ST_NODIR;
        else if (!ino_found)               fail_code <= fba_pkg::ST_NOINODE;
        else                               fail_code <= fba_pkg::ST_OK;
        rd_addr <= (fba_pkg::WordIW+1)'(1);
        rd_live <= 1'b1;
      end
      if (cmd.scan_step) begin
        // Stay on a row while it has free bits; move on once it is full.
        if (rd_live && bit_found && got != need) begin
          inode_list[{ino_sel, got[fba_pkg::OrdW-1:0]}] <= hit_blk;
          got      <= got + 1'b1;
          free_cnt <= free_cnt - 1'b1;
          rd_addr  <= {1'b0, rd_word_addr};
          rd_live  <= 1'b0;
        end else begin
          if (rd_live) rd_addr <= rd_addr + 1'b1;
          rd_live <= 1'b1;
        end
      end
      if (cmd.emit_fail) begin
        strobe        <= 1'b1;
        status        <= fail_code;
        dir_slot      <= '0;
        inode_slot    <= '0;
        block_valid   <= 1'b0;
        block_number  <= '0;
        block_ordinal <= '0;
        last          <= 1'b1;
        free_bytes    <= fba_pkg::FreeW'({free_cnt, {fba_pkg::ShiftW{1'b0}}});
      end
      if (cmd.emit_ok) begin
        dir_map[dir_sel]        <= 1'b1;
        inode_map[ino_sel]      <= 1'b1;
        dir_inode_link[dir_sel] <= ino_sel;
        inode_size[ino_sel]     <= fba_pkg::InodeSizeW'(size);
        inode_cnt[ino_sel]      <= got;
      end
      if (emit_on_d) begin
        strobe        <= 1'b1;
        status        <= fba_pkg::ST_OK;
        dir_slot      <= dir_sel;
        inode_slot    <= ino_sel;
        block_valid   <= (got != '0);
        block_number  <= (got != '0) ? fba_pkg::BnumW'(emit_blk) +
                         fba_pkg::BnumW'(fba_pkg::FirstDataBlock) : '0;
        block_ordinal <= fba_pkg::OrdW'(emit_ord_d);
        last          <= (emit_ord_d + 1'b1 >= got);
        free_bytes    <= fba_pkg::FreeW'({free_cnt, {fba_pkg::ShiftW{1'b0}}});
      end
    end
  end

  // Result sweep for successful requests: replay the block list by ordinal.
  always_ff @(posedge clk) begin
    emit_blk <= inode_list[{ino_sel, emit_ord[fba_pkg::OrdW-1:0]}];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_on   <= 1'b0;
      emit_on_d <= 1'b0;
      emit_ord  <= '0;
    end else begin
      emit_on_d  <= emit_on;
      emit_ord_d <= emit_ord;
      if (cmd.emit_ok) begin
        emit_on  <= 1'b1;
        emit_ord <= '0;
      end else if (emit_on) begin
        if (emit_ord + 1'b1 >= got) emit_on <= 1'b0;
        emit_ord <= emit_ord + 1'b1;
      end
    end
  end

  // Stores kept as written state; nothing in this block reads them back.
  logic unused_ok;
  assign unused_ok = ^{dir_inode_link[0], inode_size[0], inode_cnt[0]};

endmodule

// ===== rtl/fba_ctrl.sv =====
// fba_ctrl: controller state machine for the file block allocator.
// Depends on fba_pkg; drives fba_datapath through fba_pkg::cmd_t.
module fba_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            emit_busy,
  input  fba_pkg::stat_t  stat,
  output fba_pkg::cmd_t   cmd,
  output logic            busy
);

  fba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= fba_pkg::S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fba_pkg::S_CLEAR: if (stat.clear_done) state_next = fba_pkg::S_IDLE;
      fba_pkg::S_IDLE:  if (start) state_next = fba_pkg::S_CHECK;
      fba_pkg::S_CHECK: state_next = fba_pkg::S_SCAN;
      fba_pkg::S_SCAN: begin
        if (stat.fail) state_next = fba_pkg::S_DONE;
        else if (stat.need_done || stat.scan_end) state_next = fba_pkg::S_EMIT;
      end
      fba_pkg::S_EMIT:  state_next = fba_pkg::S_DONE;
      fba_pkg::S_DONE:  if (!emit_busy) state_next = fba_pkg::S_IDLE;
      default:          state_next = fba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      fba_pkg::S_CLEAR: cmd.clear_step = 1'b1;
      fba_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      fba_pkg::S_CHECK: cmd.check = 1'b1;
      fba_pkg::S_SCAN: begin
        if (stat.fail) cmd.emit_fail = 1'b1;
        else if (!(stat.need_done || stat.scan_end)) cmd.scan_step = 1'b1;
      end
      fba_pkg::S_EMIT:  cmd.emit_ok = 1'b1;
      fba_pkg::S_DONE:  ;
      default:          ;
    endcase
  end

endmodule

// ===== rtl/file_block_allocator.sv =====
// file_block_allocator: first-fit allocator of directory slot, inode and data blocks.
// Flow: a check step, then a scan that claims each block and walks the
//   bitmap rows (64 rows of 64 blocks), then one result beat per block.
// Throughput: one request at a time; busy stays high past the last beat.
// Reset: synchronous rst, then a clearing pass over the 64 rows of the block bitmap.
// The receiver cannot stall: each result beat shows for exactly one cycle.
module file_block_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [fba_pkg::SizeW-1:0]         file_size_bytes,
  output logic                              strobe,
  output logic [fba_pkg::StatusW-1:0]       status,
  output logic [fba_pkg::SlotW-1:0]         dir_slot,
  output logic [fba_pkg::SlotW-1:0]         inode_slot,
  output logic                              block_valid,
  output logic [fba_pkg::BnumW-1:0]         block_number,
  output logic [fba_pkg::OrdW-1:0]          block_ordinal,
  output logic [fba_pkg::FreeW-1:0]         free_bytes,
  output logic                              last
);

  fba_pkg::cmd_t  cmd;
  fba_pkg::stat_t stat;
  logic           emit_busy;
  logic [2:0]     tail;

  // Hold busy until the result sweep has drained (registered read of the block list).
  always_ff @(posedge clk) begin
    if (rst) tail <= '0;
    else if (cmd.emit_ok || cmd.emit_fail) tail <= 3'd4;
    else if (strobe && !last) tail <= 3'd3;
    else if (tail != '0) tail <= tail - 1'b1;
  end
  assign emit_busy = (tail != '0) || cmd.emit_ok;

  fba_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .emit_busy(emit_busy),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  fba_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .size_in(file_size_bytes),
    .strobe(strobe), .status(status), .dir_slot(dir_slot), .inode_slot(inode_slot),
    .block_valid(block_valid), .block_number(block_number),
    .block_ordinal(block_ordinal), .free_bytes(free_bytes), .last(last)
  );

  // A refusal is always a single final beat.
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    strobe && status != fba_pkg::ST_OK |-> last)
    else $error("refusal beat without last");

  // No request is taken while a result is going out.
  a_no_start_on_beat: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("idle while emitting");

  // Block numbers never fall below the data area.
  a_block_range: assert property (@(posedge clk) disable iff (rst)
    strobe && block_valid |-> block_number >= fba_pkg::BnumW'(fba_pkg::FirstDataBlock))
    else $error("block number below data area");

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for file_block_allocator (first-fit slot and block claims).
// Depends on rtl/fba_pkg.sv and rtl/file_block_allocator.sv; keeps its own model of the store.
`timescale 1ns / 100ps

module tb_top;

  localparam int LimitBytes = fba_pkg::BlocksPerFile * fba_pkg::BlockBytes;
  localparam int CycleLimit = 600000;

  // One result beat as the block shows it.
  typedef struct {
    fba_pkg::status_t           st;
    logic [fba_pkg::SlotW-1:0]  dir;
    logic [fba_pkg::SlotW-1:0]  ino;
    logic                       bval;
    logic [fba_pkg::BnumW-1:0]  bnum;
    logic [fba_pkg::OrdW-1:0]   ord;
    logic [fba_pkg::FreeW-1:0]  fbytes;
    logic                       fin;
  } alloc_beat_t;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic [fba_pkg::SizeW-1:0]   file_size_bytes;
  logic                        strobe;
  logic [fba_pkg::StatusW-1:0] status;
  logic [fba_pkg::SlotW-1:0]   dir_slot;
  logic [fba_pkg::SlotW-1:0]   inode_slot;
  logic                        block_valid;
  logic [fba_pkg::BnumW-1:0]   block_number;
  logic [fba_pkg::OrdW-1:0]    block_ordinal;
  logic [fba_pkg::FreeW-1:0]   free_bytes;
  logic                        last;

  file_block_allocator u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .file_size_bytes(file_size_bytes),
    .strobe         (strobe),
    .status         (status),
    .dir_slot       (dir_slot),
    .inode_slot     (inode_slot),
    .block_valid    (block_valid),
    .block_number   (block_number),
    .block_ordinal  (block_ordinal),
    .free_bytes     (free_bytes),
    .last           (last)
  );

  // Own copy of the allocation state; files are never removed, so it only fills up.
  bit          blk_taken [fba_pkg::DataBlocks];
  int          free_blks;
  bit          dir_taken [fba_pkg::FileSlots];
  bit          ino_taken [fba_pkg::FileSlots];

  alloc_beat_t pending_beats[$];
  int          fails;
  int          cycles;
  int          reqs_sent;
  int          files_made;
  int          beats_seen;
  int          refusals [5];
  bit          idle_on;

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Work out every beat that one accepted request must produce and queue them in order.
  task automatic predict_alloc(input logic [fba_pkg::SizeW-1:0] sz);
    alloc_beat_t       b;
    int                dir;
    int                ino;
    int                need;
    int                got;
    int                picked [fba_pkg::BlocksPerFile];
    fba_pkg::status_t  why;
    dir  = -1;
    ino  = -1;
    got  = 0;
    why  = fba_pkg::ST_OK;
    for (int i = fba_pkg::FileSlots - 1; i >= 0; i--) if (!dir_taken[i]) dir = i;
    for (int i = fba_pkg::FileSlots - 1; i >= 0; i--) if (!ino_taken[i]) ino = i;
    // Refusal order: too large, short of space, no directory slot, no inode.
    if (sz > LimitBytes) why = fba_pkg::ST_TOOBIG;
    else if (sz > free_blks * fba_pkg::BlockBytes) why = fba_pkg::ST_NOSPACE;
    else if (dir < 0) why = fba_pkg::ST_NODIR;
    else if (ino < 0) why = fba_pkg::ST_NOINODE;
    b = '{st: why, dir: '0, ino: '0, bval: 1'b0, bnum: '0, ord: '0, fbytes: '0, fin: 1'b1};
    if (why != fba_pkg::ST_OK) begin
      b.fbytes = fba_pkg::FreeW'(free_blks * fba_pkg::BlockBytes);
      pending_beats.push_back(b);
      refusals[why]++;
      return;
    end
    dir_taken[dir] = 1'b1;
    ino_taken[ino] = 1'b1;
    files_made++;
    need = (sz + fba_pkg::BlockBytes - 1) / fba_pkg::BlockBytes;
    for (int k = 0; k < need && k < fba_pkg::BlocksPerFile; k++) begin
      int hit;
      hit = -1;
      for (int j = fba_pkg::DataBlocks - 1; j >= 0; j--) if (!blk_taken[j]) hit = j;
      if (hit < 0) break;
      blk_taken[hit] = 1'b1;
      free_blks--;
      picked[k] = hit;
      got++;
    end
    b.dir    = fba_pkg::SlotW'(dir);
    b.ino    = fba_pkg::SlotW'(ino);
    b.fbytes = fba_pkg::FreeW'(free_blks * fba_pkg::BlockBytes);
    // Empty file: a single beat with no block attached.
    if (got == 0) begin
      pending_beats.push_back(b);
      return;
    end
    for (int k = 0; k < got; k++) begin
      b.bval = 1'b1;
      b.bnum = fba_pkg::BnumW'(fba_pkg::FirstDataBlock + picked[k]);
      b.ord  = fba_pkg::OrdW'(k);
      b.fin  = (k == got - 1);
      pending_beats.push_back(b);
    end
  endtask

  // Send one request: optional idle burst, then hold start until the block takes the beat.
  task automatic send_req(input logic [fba_pkg::SizeW-1:0] sz);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      file_size_bytes <= fba_pkg::SizeW'($urandom);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    file_size_bytes <= sz;
    // Accepted at the first edge where busy was low while start was high.
    do @(posedge clk); while (busy);
    predict_alloc(sz);
    reqs_sent++;
  endtask

  // Drop start and hold until every queued beat has come back.
  task automatic drain_beats();
    start <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [fba_pkg::SizeW-1:0] pick_size();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 20)
      return fba_pkg::SizeW'($urandom_range(LimitBytes + 1, (1 << fba_pkg::SizeW) - 1));
    if (r < 35) return fba_pkg::SizeW'($urandom_range(0, fba_pkg::BlockBytes));
    if (r < 50) begin
      // Land on or next to a block boundary to stress the rounding up.
      k = $urandom_range(1, fba_pkg::BlocksPerFile);
      return fba_pkg::SizeW'(k * fba_pkg::BlockBytes + $urandom_range(0, 2) - 1);
    end
    return fba_pkg::SizeW'($urandom_range(0, LimitBytes));
  endfunction

  // Directed extremes: empty file, one byte, block edges, the size cap and beyond.
  task automatic test_extremes();
    send_req('0);
    send_req(fba_pkg::SizeW'(1));
    send_req(fba_pkg::SizeW'(fba_pkg::BlockBytes));
    send_req(fba_pkg::SizeW'(fba_pkg::BlockBytes + 1));
    send_req(fba_pkg::SizeW'(LimitBytes - 1));
    send_req(fba_pkg::SizeW'(LimitBytes));
    send_req(fba_pkg::SizeW'(LimitBytes + 1));
    send_req('1);
    send_req(fba_pkg::SizeW'(1 << (fba_pkg::SizeW - 1)));
    send_req(fba_pkg::SizeW'(2 * fba_pkg::BlockBytes - 1));
    send_req('0);
  endtask

  // Random mix with idle bursts; this fills the directory and inode table.
  task automatic test_random_mix(input int n);
    idle_on = 1'b1;
    for (int i = 0; i < n; i++) send_req(pick_size());
  endtask

  // Hold off the sender until the block is idle, then go on.
  task automatic test_pause_until_idle();
    drain_beats();
    send_req(fba_pkg::SizeW'(3 * fba_pkg::BlockBytes));
    drain_beats();
  endtask

  // Store full: every fitting size now runs out of directory slots.
  task automatic test_full_store();
    while (files_made < fba_pkg::FileSlots)
      send_req(fba_pkg::SizeW'($urandom_range(0, LimitBytes)));
    send_req('0);
    send_req(fba_pkg::SizeW'(1));
    send_req(fba_pkg::SizeW'(LimitBytes));
    send_req('1);
  endtask

  // Back-to-back tail with no idling.
  task automatic test_back_to_back(input int n);
    idle_on = 1'b0;
    for (int i = 0; i < n; i++) send_req(pick_size());
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    file_size_bytes = '0;
    idle_on         = 1'b0;
    fails           = 0;
    reqs_sent       = 0;
    files_made      = 0;
    beats_seen      = 0;
    free_blks       = fba_pkg::DataBlocks;
    foreach (refusals[i]) refusals[i] = 0;
    foreach (blk_taken[i]) blk_taken[i] = 1'b0;
    foreach (dir_taken[i]) dir_taken[i] = 1'b0;
    foreach (ino_taken[i]) ino_taken[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_random_mix(250);
    test_pause_until_idle();
    test_full_store();
    test_random_mix(60);
    test_back_to_back(60);

    drain_beats();
    repeat (200) @(posedge clk);
    $display("%0d requests, %0d files created, %0d result beats checked", reqs_sent,
             files_made, beats_seen);
    $display("refused: %0d too large, %0d short of space, %0d no directory slot",
             refusals[fba_pkg::ST_TOOBIG], refusals[fba_pkg::ST_NOSPACE],
             refusals[fba_pkg::ST_NODIR]);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  function automatic void cmp_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endfunction

  // Check each strobed beat against the oldest expectation.
  always @(posedge clk) begin
    alloc_beat_t e;
    if (!rst && strobe) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %0d", $time,
                 status);
        fails++;
      end else begin
        e = pending_beats.pop_front();
        cmp_field("status", e.st, status);
        cmp_field("dir_slot", e.dir, dir_slot);
        cmp_field("inode_slot", e.ino, inode_slot);
        cmp_field("block_valid", e.bval, block_valid);
        cmp_field("block_number", e.bnum, block_number);
        cmp_field("block_ordinal", e.ord, block_ordinal);
        cmp_field("free_bytes", e.fbytes, free_bytes);
        cmp_field("last", e.fin, last);
      end
    end
  end

  // Watchdog: a hung block ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d beats outstanding", $time, pending_beats.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial cycles = 0;

endmodule
